@@ hw/rtl/animation_frame_sequencer_defines.svh @@
// Assertion macros used by the checker file of the frame sequencer.
`ifndef ANIMATION_FRAME_SEQUENCER_DEFINES_SVH
`define ANIMATION_FRAME_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/afs_pkg.sv @@
`timescale 1ns / 1ps

package afs_pkg;

	// Stream and configuration widths
	localparam int S_TDATA_W  = 56;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 32;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 10;

	// Offset limit after a start, and remainder unit length
	localparam int unsigned OFFSET_CAP = 60000;
	localparam int DIV_STEPS  = 32;

	localparam logic [9:0] TICK_MS_RESET = 10'd20;

	// Action codes carried in s_tuser
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	// Configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_FRAME_COUNT = 1'b0,
		REG_TICK_MS     = 1'b1
	} reg_idx_t;

	// Controller to datapath commands
	typedef struct packed {
		logic take_in;
		logic mem_wr;
		logic div_start_cur;
		logic div_start_pos;
		logic div_step;
		logic disp_from_cur;
		logic disp_from_rem;
		logic cur_from_disp;
		logic off_add_tick;
		logic off_zero;
		logic off_from_rem;
		logic sum_clear;
		logic sum_rd;
		logic walk_init;
		logic walk_rd;
		logic walk_adv;
		logic out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_start;
		logic is_tick;
		logic is_load;
		logic multi;
		logic cur_ge_n;
		logic div_last;
		logic sum_last;
		logic total_zero;
		logic walk_stop;
		logic zero_stop;
		logic out_busy;
	} status_t;

endpackage

@@ hw/rtl/afs_ctrl.sv @@
`timescale 1ns / 1ps

module afs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  afs_pkg::status_t sts,
	output afs_pkg::cmd_t   cmd
);
	import afs_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE     = 13'b0000000000001,
		ST_DISPATCH = 13'b0000000000010,
		ST_MODCUR   = 13'b0000000000100,
		ST_CURTAKE  = 13'b0000000001000,
		ST_NORMDONE = 13'b0000000010000,
		ST_SUM      = 13'b0000000100000,
		ST_SUMTAIL  = 13'b0000001000000,
		ST_POSSTART = 13'b0000010000000,
		ST_MODPOS   = 13'b0000100000000,
		ST_POSTAKE  = 13'b0001000000000,
		ST_WALKRD   = 13'b0010000000000,
		ST_WALKCMP  = 13'b0100000000000,
		ST_FINISH   = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);

	// Next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take_in = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				cmd.mem_wr = sts.is_load;
				if (!sts.multi) begin
					state_d = ST_FINISH;
				end else if (sts.cur_ge_n) begin
					cmd.div_start_cur = 1'b1;
					state_d           = ST_MODCUR;
				end else begin
					cmd.disp_from_cur = 1'b1;
					state_d           = ST_NORMDONE;
				end
			end
			ST_MODCUR: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = ST_CURTAKE;
			end
			ST_CURTAKE: begin
				cmd.disp_from_rem = 1'b1;
				state_d           = ST_NORMDONE;
			end
			ST_NORMDONE: begin
				if (sts.is_start) begin
					cmd.cur_from_disp = 1'b1;
					cmd.sum_clear     = 1'b1;
					state_d           = ST_SUM;
				end else if (sts.is_tick) begin
					cmd.cur_from_disp = 1'b1;
					cmd.off_add_tick  = 1'b1;
					cmd.walk_init     = 1'b1;
					state_d           = ST_WALKRD;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SUM: begin
				cmd.sum_rd = 1'b1;
				if (sts.sum_last)
					state_d = ST_SUMTAIL;
			end
			ST_SUMTAIL: begin
				state_d = ST_POSSTART;
			end
			ST_POSSTART: begin
				if (sts.total_zero) begin
					cmd.off_zero  = 1'b1;
					cmd.walk_init = 1'b1;
					state_d       = ST_WALKRD;
				end else begin
					cmd.div_start_pos = 1'b1;
					state_d           = ST_MODPOS;
				end
			end
			ST_MODPOS: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = ST_POSTAKE;
			end
			ST_POSTAKE: begin
				cmd.off_from_rem = 1'b1;
				cmd.walk_init    = 1'b1;
				state_d          = ST_WALKRD;
			end
			ST_WALKRD: begin
				cmd.walk_rd = 1'b1;
				state_d     = ST_WALKCMP;
			end
			ST_WALKCMP: begin
				if (sts.walk_stop || sts.zero_stop) begin
					cmd.disp_from_cur = 1'b1;
					state_d           = ST_FINISH;
				end else begin
					cmd.walk_adv = 1'b1;
					state_d      = ST_WALKRD;
				end
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/afs_dpath.sv @@
`timescale 1ns / 1ps

module afs_dpath #(
	parameter int MAX_FRAMES = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [afs_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic [afs_pkg::S_TUSER_W-1:0]     s_tuser,
	input  logic                              cfg_we,
	input  logic [afs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [afs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  afs_pkg::cmd_t                     cmd,
	output afs_pkg::status_t                  sts,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [afs_pkg::M_TDATA_W-1:0]     m_tdata
);
	import afs_pkg::*;

	localparam int IW  = $clog2(MAX_FRAMES);
	localparam int NW  = $clog2(MAX_FRAMES + 1);
	localparam int TW  = 16 + IW;
	localparam int DCW = $clog2(DIV_STEPS);

	// Configuration
	logic [8:0]     frame_count_q;
	logic [9:0]     tick_q;
	logic [NW-1:0]  n_w;

	// Latched item
	logic [1:0]     act_q;
	logic [7:0]     entry_q;
	logic [15:0]    dur_q;
	logic [31:0]    pos_q;

	// Frame state and work registers
	logic [IW-1:0]  cur_q;
	logic [16:0]    off_q;
	logic [IW-1:0]  disp_q;
	logic [NW-1:0]  zrun_q;
	logic [NW-1:0]  idx_q;
	logic [TW-1:0]  total_q;
	logic           pend_q;

	// Remainder unit
	logic [31:0]    dvd_q;
	logic [TW-1:0]  dvs_q;
	logic [TW-1:0]  rem_q;
	logic [DCW-1:0] dcnt_q;
	logic [TW:0]    rem_sh;
	logic [TW-1:0]  rem_nx;

	// Duration table
	logic [15:0]    mem_q [MAX_FRAMES];
	logic [15:0]    rdata_q;
	logic           wr_en;
	logic [15:0]    wr_data;
	logic           rd_en;
	logic [IW-1:0]  rd_addr;

	// Output register
	logic           m_tvalid_q;
	logic [7:0]     fr_out_q;
	logic [15:0]    off_out_q;
	logic           has_out_q;
	logic           anim_out_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			tick_q        <= TICK_MS_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_FRAME_COUNT: frame_count_q <= cfg_wdata[8:0];
				REG_TICK_MS:     tick_q        <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	// Frames in use, limited to the table depth
	assign n_w = (32'(frame_count_q) > 32'(MAX_FRAMES)) ? NW'(MAX_FRAMES)
	                                                   : NW'(frame_count_q);

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			act_q   <= s_tuser;
			entry_q <= s_tdata[7:0];
			dur_q   <= s_tdata[23:8];
			pos_q   <= s_tdata[55:24];
		end
	end

	// Table write and registered read
	assign wr_en   = cmd.mem_wr && (32'(entry_q) < 32'(MAX_FRAMES));
	assign wr_data = (dur_q == 16'd0) ? 16'd1 : dur_q;
	assign rd_en   = cmd.sum_rd || cmd.walk_rd;
	assign rd_addr = cmd.sum_rd ? idx_q[IW-1:0] : cur_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[IW'(entry_q)] <= wr_data;
		if (rd_en)
			rdata_q <= mem_q[rd_addr];
	end

	// One remainder bit per step
	assign rem_sh = {rem_q, dvd_q[31]};
	assign rem_nx = (rem_sh >= {1'b0, dvs_q}) ? TW'(rem_sh - {1'b0, dvs_q}) : rem_sh[TW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.div_start_cur) begin
			dvd_q  <= 32'(cur_q);
			dvs_q  <= TW'(n_w);
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_start_pos) begin
			dvd_q  <= pos_q;
			dvs_q  <= total_q;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[30:0], 1'b0};
			rem_q  <= rem_nx;
			dcnt_q <= dcnt_q + DCW'(1);
		end
	end

	// Duration sum over frames in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= cmd.sum_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_clear) begin
			idx_q   <= '0;
			total_q <= '0;
		end else begin
			if (cmd.sum_rd)
				idx_q <= idx_q + NW'(1);
			if (pend_q)
				total_q <= total_q + TW'(rdata_q);
		end
	end

	// Current frame and offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			off_q <= '0;
		end else begin
			if (cmd.cur_from_disp)
				cur_q <= disp_q;
			else if (cmd.walk_adv)
				cur_q <= (NW'(cur_q) + NW'(1) == n_w) ? '0 : cur_q + IW'(1);

			if (cmd.off_add_tick)
				off_q <= off_q + 17'(tick_q);
			else if (cmd.off_zero)
				off_q <= '0;
			else if (cmd.off_from_rem)
				off_q <= (rem_q > TW'(OFFSET_CAP)) ? 17'(OFFSET_CAP) : 17'(rem_q);
			else if (cmd.walk_adv)
				off_q <= off_q - 17'(rdata_q);
		end
	end

	// Shown frame and run of empty durations
	always_ff @(posedge clk) begin
		if (cmd.disp_from_cur)
			disp_q <= cur_q;
		else if (cmd.disp_from_rem)
			disp_q <= rem_q[IW-1:0];

		if (cmd.walk_init)
			zrun_q <= '0;
		else if (cmd.walk_adv)
			zrun_q <= (rdata_q == 16'd0) ? zrun_q + NW'(1) : '0;
	end

	// Status to controller
	assign sts.is_start   = (act_q == ACT_START);
	assign sts.is_tick    = (act_q == ACT_TICK);
	assign sts.is_load    = (act_q == ACT_LOAD);
	assign sts.multi      = (n_w > NW'(1));
	assign sts.cur_ge_n   = (NW'(cur_q) >= n_w);
	assign sts.div_last   = (dcnt_q == DCW'(DIV_STEPS - 1));
	assign sts.sum_last   = (idx_q == n_w - NW'(1));
	assign sts.total_zero = (total_q == '0);
	assign sts.walk_stop  = (off_q <= 17'(rdata_q));
	assign sts.zero_stop  = (rdata_q == 16'd0) &&
	                        ({1'b0, zrun_q} + (NW+1)'(1) >= {1'b0, n_w});
	assign sts.out_busy   = m_tvalid_q && !m_tready;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			fr_out_q   <= sts.multi ? 8'(disp_q) : 8'd0;
			off_out_q  <= (n_w == '0) ? 16'd0 : (off_q[16] ? 16'hFFFF : off_q[15:0]);
			has_out_q  <= (n_w != '0);
			anim_out_q <= sts.multi;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, anim_out_q, has_out_q, off_out_q, fr_out_q};

endmodule

@@ hw/rtl/animation_frame_sequencer.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Transaction
// s_*       in   one item: tuser = action, tdata = entry_index, duration, timer_position
// m_*       out  one result per item: frame_index, offset_ms, has_frames, is_animated
// cfg_*     in   register write: 0 frame_count, 1 tick_ms
//
// One item at a time; s_tready is high only while the controller is idle.
// Load or unused action: dispatch and finish, with a normalize step for two or more frames.
// Tick: walk frames. Start: table sum, 32-step remainder unit, walk. Sum and walk read one
// table entry per step. A stored frame index not below frame_count adds a remainder pass.
// Reset clears control, frame_count, frame and offset, sets tick_ms to 20; not the table.
// A result held by m_tready low stalls the controller only at its final step.

module animation_frame_sequencer #(
	parameter int MAX_FRAMES = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [7:0] entry_index, [23:8] duration, [55:24] timer_position
	input  logic [afs_pkg::S_TDATA_W-1:0]  s_tdata,
	// [1:0] action
	input  logic [afs_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [7:0] frame_index, [23:8] offset_ms, [24] has_frames, [25] is_animated, [31:26] zero
	output logic [afs_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                           cfg_we,
	input  logic [afs_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [afs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import afs_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// Sequencer
	afs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Table, remainder unit, frame state and output register
	afs_dpath #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

@@ hw/rtl/afs_checker.sv @@
`timescale 1ns / 1ps
`include "animation_frame_sequencer_defines.svh"

module afs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [afs_pkg::M_TDATA_W-1:0] m_tdata
);

	// Result held while stalled
	`AFS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`AFS_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

	// One item at a time: input closes right after a transaction
	`AFS_ASSERT_NEXT(a_in_busy, s_tvalid && s_tready, !s_tready, "second item taken while busy")

	// No frames: index and offset read zero
	`AFS_ASSERT_NOW(a_empty_zero, m_tvalid && !m_tdata[24], m_tdata[23:0] == 24'd0, "nonzero result with no frames")

	// Animated only with frames; a still image shows frame zero
	`AFS_ASSERT_NOW(a_flags, m_tvalid && !m_tdata[25], !m_tdata[24] || (m_tdata[7:0] == 8'd0), "still image frame not zero")

endmodule

bind animation_frame_sequencer afs_checker u_afs_checker (.*);
